// ----- hdl/verlet_point_collision_step_unit_assert.svh -----
// ----------------------------------------------------------------------------
// verlet point collision step assertion macros
// concurrent checks on clk with rst_n as the disable term
// ----------------------------------------------------------------------------
`ifndef VERLET_POINT_COLLISION_STEP_UNIT_ASSERT_SVH
`define VERLET_POINT_COLLISION_STEP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// implication in the same cycle
`define VPCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpcs assertion failed");

// implication in the next cycle
`define VPCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpcs assertion failed");

`else

`define VPCS_ASSERT_SAME(lbl, ante, cons)
`define VPCS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/vpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// vpcs_pkg
// command, direction and register codes plus rounding and saturation helpers
// ----------------------------------------------------------------------------
package vpcs_pkg;

    // command codes
    localparam logic [1:0] MODE_INTEGRATE = 2'd0;
    localparam logic [1:0] MODE_COLLIDE   = 2'd1;
    localparam logic [1:0] MODE_MOVE      = 2'd2;
    localparam logic [1:0] MODE_PLACE     = 2'd3;

    // move directions, other codes act as none
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_DRAG     = 3'd0;
    localparam logic [2:0] REG_GRAVITY  = 3'd1;
    localparam logic [2:0] REG_FRICTION = 3'd2;
    localparam logic [2:0] REG_BOUNCE   = 3'd3;
    localparam logic [2:0] REG_PUSH     = 3'd4;
    localparam logic [2:0] REG_LIMIT    = 3'd5;

    // register reset values
    localparam logic [15:0] DRAG_RESET     = 16'd32440;
    localparam logic [31:0] GRAVITY_RESET  = 32'd13107;
    localparam logic [15:0] FRICTION_RESET = 16'd1638;
    localparam logic [15:0] BOUNCE_RESET   = 16'd9830;

    // datapath widths
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int IMP_W   = 40;
    localparam int WB_W    = 48;

    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [MUL_A_W-1:0] opa_t;
    typedef logic signed [IMP_W-1:0]   imp_t;
    typedef logic signed [WB_W-1:0]    wide_t;

    localparam wide_t SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam wide_t SAT_MIN = 48'shFFFF_8000_0000;

    // round to nearest by 2^14, ties up, result narrowed to operand width
    function automatic opa_t rnd14(input prod_t p);
        prod_t s;
        s = p + prod_t'(8192);
        return s[MUL_A_W+13:14];
    endfunction

    // round to nearest by 2^15, ties up
    function automatic imp_t rnd15(input prod_t p);
        prod_t s;
        s = p + prod_t'(16384);
        return {s[PROD_W-1], s[PROD_W-1:15]};
    endfunction

    // clamp into the signed 32 bit range
    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/verlet_point_collision_step_unit.sv -----
// ----------------------------------------------------------------------------
// verlet_point_collision_step_unit
// one verlet point: integrate, collide, move and place on a shared multiplier
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tuser: mode, tdata: vec_x vec_y normal_x normal_y direction
//  m_axis    out        tdata: pos_x pos_y
//  cfg       in         cfg_index, cfg_data register write, always ready
//
//  the single 37x17 multiplier computes two products for integrate and eight
//  dependent ones for collide, one issued per cycle
//  s_tready is high only while no request is in work
//  a waiting result does not block the next request; write-back holds until
//  the output register is free
//  reset clears the point to the origin and the registers to their defaults
// ----------------------------------------------------------------------------
`include "verlet_point_collision_step_unit_assert.svh"

module verlet_point_collision_step_unit
    import vpcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // vec_x, vec_y, normal_x, normal_y, direction, zero fill
    input  logic [1:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // pos_x, pos_y
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    localparam logic [3:0] STEP_LAST_INT = 4'd2;
    localparam logic [3:0] STEP_LAST_COL = 4'd9;
    localparam logic [3:0] STEP_LAST_MOV = 4'd0;

    // configuration registers
    logic        [15:0] drag_reg;
    logic signed [31:0] gravity_reg;
    logic        [15:0] friction_reg;
    logic        [15:0] bounce_reg;
    logic        [30:0] push_reg;
    logic        [30:0] limit_reg;

    // point state
    logic signed [31:0] cur_x_reg, cur_y_reg, prev_x_reg, prev_y_reg;

    // captured request
    logic        [1:0]  mode_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic        [2:0]  dir_reg;

    // sequencer
    logic [1:0] state_reg, state_next;
    logic [3:0] step_reg;
    logic [3:0] step_last;

    // datapath
    prod_t prod_reg;
    prod_t acc_reg;
    prod_t dp;
    opa_t  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    opa_t  d16_reg, nx_reg, ny_reg, tx_reg, ty_reg;
    imp_t  ix_reg, iy_reg;
    logic  neg_reg;
    logic signed [32:0] vx, vy;

    // move velocity
    logic signed [35:0] sp36, lim36, fx, fy, sum_x, sum_y, cl_x, cl_y;

    // write-back
    logic               wb_fire;
    logic signed [31:0] new_cx, new_cy, new_px, new_py;
    imp_t               ix_eff, iy_eff;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign vx = {cur_x_reg[31], cur_x_reg} - {prev_x_reg[31], prev_x_reg};
    assign vy = {cur_y_reg[31], cur_y_reg} - {prev_y_reg[31], prev_y_reg};

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_reg     <= DRAG_RESET;
            gravity_reg  <= GRAVITY_RESET;
            friction_reg <= FRICTION_RESET;
            bounce_reg   <= BOUNCE_RESET;
            push_reg     <= '0;
            limit_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DRAG:     drag_reg     <= cfg_data[15:0];
                REG_GRAVITY:  gravity_reg  <= cfg_data;
                REG_FRICTION: friction_reg <= cfg_data[15:0];
                REG_BOUNCE:   bounce_reg   <= cfg_data[15:0];
                REG_PUSH:     push_reg     <= cfg_data[30:0];
                REG_LIMIT:    limit_reg    <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // last run step of the current command
    always_comb
    begin
        case (mode_reg)
            MODE_INTEGRATE: step_last = STEP_LAST_INT;
            MODE_COLLIDE:   step_last = STEP_LAST_COL;
            default:        step_last = STEP_LAST_MOV;
        endcase
    end

    assign wb_fire = (state_reg == ST_WB) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == MODE_PLACE) ? ST_WB : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == step_last)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (wb_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RUN)
            begin
                step_reg <= step_reg + 4'd1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg <= s_tuser;
            px_reg   <= s_tdata[31:0];
            py_reg   <= s_tdata[63:32];
            dx_reg   <= s_tdata[79:64];
            dy_reg   <= s_tdata[95:80];
            dir_reg  <= s_tdata[98:96];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = MUL_A_W'(vx);
        mul_b = MUL_B_W'(dx_reg);
        if (mode_reg == MODE_INTEGRATE)
        begin
            mul_a = (step_reg == 4'd0) ? MUL_A_W'(vx) : MUL_A_W'(vy);
            mul_b = $signed({1'b0, drag_reg});
        end
        else
        begin
            case (step_reg)
                4'd0:    begin mul_a = MUL_A_W'(vx); mul_b = MUL_B_W'(dx_reg); end
                4'd1:    begin mul_a = MUL_A_W'(vy); mul_b = MUL_B_W'(dy_reg); end
                4'd3:    begin mul_a = d16_reg; mul_b = MUL_B_W'(dx_reg); end
                4'd4:    begin mul_a = d16_reg; mul_b = MUL_B_W'(dy_reg); end
                4'd5:    begin mul_a = nx_reg; mul_b = $signed({1'b0, bounce_reg}); end
                4'd6:    begin mul_a = ny_reg; mul_b = $signed({1'b0, bounce_reg}); end
                4'd7:    begin mul_a = tx_reg; mul_b = $signed({1'b0, friction_reg}); end
                4'd8:    begin mul_a = ty_reg; mul_b = $signed({1'b0, friction_reg}); end
                default: ;
            endcase
        end
    end

    assign dp = acc_reg + prod_reg;

    // move push and per-axis speed clamp
    always_comb
    begin
        sp36  = $signed({5'd0, push_reg});
        lim36 = $signed({5'd0, limit_reg});
        fx    = '0;
        fy    = '0;
        case (dir_reg)
            DIR_LEFT:  fx = -sp36;
            DIR_RIGHT: fx = sp36;
            DIR_UP:    fy = -(sp36 + 36'(gravity_reg));
            DIR_DOWN:  fy = sp36;
            default:   ;
        endcase
        sum_x = 36'(vx) + fx;
        sum_y = 36'(vy) + fy;
        cl_x  = sum_x;
        cl_y  = sum_y;
        if (sum_x > lim36)
        begin
            cl_x = lim36;
        end
        else if (sum_x < -lim36)
        begin
            cl_x = -lim36;
        end
        if (sum_y > lim36)
        begin
            cl_y = lim36;
        end
        else if (sum_y < -lim36)
        begin
            cl_y = -lim36;
        end
    end

    // product pipeline and step results
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_RUN)
        begin
            unique case (mode_reg)
                MODE_INTEGRATE:
                begin
                    if (step_reg == 4'd1)
                    begin
                        ix_reg <= rnd15(prod_reg);
                    end
                    if (step_reg == 4'd2)
                    begin
                        iy_reg <= rnd15(prod_reg);
                    end
                end
                MODE_COLLIDE:
                begin
                    case (step_reg)
                        4'd1: acc_reg <= prod_reg;
                        4'd2:
                        begin
                            neg_reg <= dp[PROD_W-1];
                            d16_reg <= rnd14(dp);
                        end
                        4'd4: nx_reg <= rnd14(prod_reg);
                        4'd5:
                        begin
                            ny_reg <= rnd14(prod_reg);
                            tx_reg <= MUL_A_W'(vx) - nx_reg;
                        end
                        4'd6:
                        begin
                            ix_reg <= IMP_W'(nx_reg) + rnd15(prod_reg);
                            ty_reg <= MUL_A_W'(vy) - ny_reg;
                        end
                        4'd7: iy_reg <= IMP_W'(ny_reg) + rnd15(prod_reg);
                        4'd8: ix_reg <= ix_reg + rnd15(prod_reg);
                        4'd9: iy_reg <= iy_reg + rnd15(prod_reg);
                        default: ;
                    endcase
                end
                MODE_MOVE:
                begin
                    ix_reg <= IMP_W'(cl_x);
                    iy_reg <= IMP_W'(cl_y);
                end
                default: ;
            endcase
        end
    end

    // new point values
    always_comb
    begin
        ix_eff = neg_reg ? ix_reg : '0;
        iy_eff = neg_reg ? iy_reg : '0;
        new_cx = cur_x_reg;
        new_cy = cur_y_reg;
        new_px = prev_x_reg;
        new_py = prev_y_reg;
        unique case (mode_reg)
            MODE_INTEGRATE:
            begin
                new_cx = sat32(WB_W'(cur_x_reg) + WB_W'(ix_reg));
                new_cy = sat32(WB_W'(cur_y_reg) + WB_W'(iy_reg) + WB_W'(gravity_reg));
                new_px = cur_x_reg;
                new_py = cur_y_reg;
            end
            MODE_COLLIDE:
            begin
                new_cx = sat32(WB_W'(cur_x_reg) + WB_W'(px_reg));
                new_cy = sat32(WB_W'(cur_y_reg) + WB_W'(py_reg));
                new_px = sat32(WB_W'(prev_x_reg) + WB_W'(px_reg) + WB_W'(ix_eff));
                new_py = sat32(WB_W'(prev_y_reg) + WB_W'(py_reg) + WB_W'(iy_eff));
            end
            MODE_MOVE:
            begin
                new_cx = sat32(WB_W'(prev_x_reg) + WB_W'(ix_reg));
                new_cy = sat32(WB_W'(prev_y_reg) + WB_W'(iy_reg));
            end
            MODE_PLACE:
            begin
                new_cx = px_reg;
                new_cy = py_reg;
                new_px = px_reg;
                new_py = py_reg;
            end
            default: ;
        endcase
    end

    // point state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (wb_fire)
        begin
            cur_x_reg  <= new_cx;
            cur_y_reg  <= new_cy;
            prev_x_reg <= new_px;
            prev_y_reg <= new_py;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (wb_fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            m_tdata_reg <= {new_cy, new_cx};
        end
    end

    // checks
    `VPCS_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready)
    `VPCS_ASSERT_SAME(a_rise_after_wb, $rose(m_tvalid), $past(wb_fire))
    `VPCS_ASSERT_NEXT(a_place_rest, wb_fire && mode_reg == MODE_PLACE,
        cur_x_reg == prev_x_reg && cur_y_reg == prev_y_reg)
    `VPCS_ASSERT_NEXT(a_int_prev, wb_fire && mode_reg == MODE_INTEGRATE,
        prev_x_reg == $past(cur_x_reg) && prev_y_reg == $past(cur_y_reg))
    `VPCS_ASSERT_SAME(a_step_range, state_reg == ST_RUN, step_reg <= step_last)

endmodule

// ----- sim/verlet_point_collision_step_unit_test.sv -----
// ----------------------------------------------------------------------------
// verlet point collision step unit testbench
// drives integrate, collide, move and place requests through the stream
// ports, predicts every new position from a local copy of the point and the
// gain registers, and checks each output word in order under several register
// settings and idle patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module verlet_point_collision_step_unit_test;
    import vpcs_pkg::*;

    // move directions the package leaves unnamed
    localparam logic [2:0] DIR_NONE = 3'd0;
    localparam logic [2:0] DIR_JUNK = 3'd7;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LIMIT_CYCLES   = 400000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic [2:0]         dir;
    } step_cmd_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    typedef struct packed {
        step_cmd_t cmd;
        logic      typed;
        point_t    pos;
    } directed_row_t;

    typedef struct packed {
        logic [15:0] drag;
        logic [31:0] gravity;
        logic [15:0] friction;
        logic [15:0] bounce;
        logic [30:0] push;
        logic [30:0] limit;
    } regset_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    // predictor copy of the point and the registers
    logic signed [31:0] here_x, here_y, last_x, last_y;
    logic [15:0]        k_drag, k_friction, k_bounce;
    logic signed [31:0] g_accel;
    logic [30:0]        v_push, v_max;

    point_t expected_pos [$];
    point_t out_want;
    int     mismatch_count;
    int     sim_cycles;
    int     sender_idle_pct;
    int     receiver_idle_pct;

    // directed requests, typed positions where they are obvious
    directed_row_t directed_rows [0:22] = '{
        '{'{MODE_INTEGRATE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sd0, 32'sd13107}},
        '{'{MODE_PLACE, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000, 16'sh7FFF, DIR_JUNK},
          1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000}},
        '{'{MODE_INTEGRATE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sh7FFF_FFFF, 32'sh8000_3333}},
        '{'{MODE_INTEGRATE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_COLLIDE, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sh7FFF_FFFF, 32'sh8000_0000}},
        '{'{MODE_MOVE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sh7FFF_FFFF, 32'sh8000_0000}},
        '{'{MODE_PLACE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sd0, 32'sd0}},
        '{'{MODE_INTEGRATE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sd0, 32'sd13107}},
        '{'{MODE_COLLIDE, 32'sd0, 32'sd0, 16'sd0, -16'sd16384, DIR_NONE}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_PLACE, 32'sh0001_0000, 32'sh0002_0000, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sh0001_0000, 32'sh0002_0000}},
        '{'{MODE_INTEGRATE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sh0001_0000, 32'sh0002_3333}},
        '{'{MODE_COLLIDE, 32'sh0000_0100, -32'sh0000_0100, 16'sd0, 16'sd16384, DIR_NONE},
          1'b1, '{32'sh0001_0100, 32'sh0002_3233}},
        '{'{MODE_COLLIDE, 32'sd0, 32'sd0, 16'sd11585, 16'sd11585, DIR_NONE}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_COLLIDE, 32'sd0, 32'sd0, -16'sd11585, -16'sd11585, DIR_NONE}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_MOVE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_LEFT}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_MOVE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_RIGHT}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_INTEGRATE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_MOVE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_UP}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_MOVE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_DOWN}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_MOVE, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000, DIR_JUNK},
          1'b0, '{32'sd0, 32'sd0}},
        '{'{MODE_COLLIDE, 32'sd4096, -32'sd4096, 16'sh8000, 16'sh7FFF, DIR_NONE}, 1'b0,
          '{32'sd0, 32'sd0}},
        '{'{MODE_PLACE, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sh8000_0000, 32'sh7FFF_FFFF}},
        '{'{MODE_INTEGRATE, 32'sd0, 32'sd0, 16'sd0, 16'sd0, DIR_NONE}, 1'b1,
          '{32'sh8000_0000, 32'sh7FFF_FFFF}}
    };

    verlet_point_collision_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // round to nearest by 2^s, ties toward plus infinity
    function automatic longint round_q(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] saturate32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint clamp_to_limit(input longint v);
        longint lim;
        lim = longint'(v_max);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    // advance the local point by one request and return the new position
    function automatic point_t advance_point(input step_cmd_t c);
        longint vx, vy, px, py, nx, ny;
        longint dot, dot16, nrm_x, nrm_y, kick_x, kick_y, push_x, push_y, sp;
        point_t r;
        vx = longint'(here_x) - longint'(last_x);
        vy = longint'(here_y) - longint'(last_y);
        px = longint'(c.vec_x);
        py = longint'(c.vec_y);
        case (c.mode)
            MODE_INTEGRATE:
            begin
                nx = longint'(here_x) + round_q(vx * longint'(k_drag), 15);
                ny = longint'(here_y) + round_q(vy * longint'(k_drag), 15)
                     + longint'(g_accel);
                last_x = here_x;
                last_y = here_y;
                here_x = saturate32(nx);
                here_y = saturate32(ny);
            end
            MODE_COLLIDE:
            begin
                dot = vx * longint'(c.normal_x) + vy * longint'(c.normal_y);
                kick_x = 0;
                kick_y = 0;
                // only a velocity into the surface gets bounce and friction
                if (dot < 0)
                begin
                    dot16 = round_q(dot, 14);
                    nrm_x = round_q(dot16 * longint'(c.normal_x), 14);
                    nrm_y = round_q(dot16 * longint'(c.normal_y), 14);
                    kick_x = nrm_x + round_q(nrm_x * longint'(k_bounce), 15)
                             + round_q((vx - nrm_x) * longint'(k_friction), 15);
                    kick_y = nrm_y + round_q(nrm_y * longint'(k_bounce), 15)
                             + round_q((vy - nrm_y) * longint'(k_friction), 15);
                end
                here_x = saturate32(longint'(here_x) + px);
                here_y = saturate32(longint'(here_y) + py);
                last_x = saturate32(longint'(last_x) + px + kick_x);
                last_y = saturate32(longint'(last_y) + py + kick_y);
            end
            MODE_MOVE:
            begin
                sp = longint'(v_push);
                push_x = 0;
                push_y = 0;
                case (c.dir)
                    DIR_LEFT:  push_x = -sp;
                    DIR_RIGHT: push_x = sp;
                    DIR_UP:    push_y = -(sp + longint'(g_accel));
                    DIR_DOWN:  push_y = sp;
                    default:   ;
                endcase
                here_x = saturate32(longint'(last_x) + clamp_to_limit(vx + push_x));
                here_y = saturate32(longint'(last_y) + clamp_to_limit(vy + push_y));
            end
            default:
            begin
                here_x = c.vec_x;
                here_y = c.vec_y;
                last_x = c.vec_x;
                last_y = c.vec_y;
            end
        endcase
        r.x = here_x;
        r.y = here_y;
        return r;
    endfunction

    // signed value spread evenly around zero over 2^bits
    function automatic logic signed [31:0] spread(input int bits);
        int span;
        span = 1 << bits;
        return $signed($urandom_range(0, span - 1)) - span / 2;
    endfunction

    function automatic logic signed [15:0] random_normal_part();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            return 16'(spread(15));
        end
        if (pick < 30)
        begin
            return 16'($urandom());
        end
        case ($urandom_range(0, 4))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            2:       return 16'sd11585;
            3:       return -16'sd11585;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic step_cmd_t random_cmd();
        step_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            c.mode = MODE_INTEGRATE;
        end
        else if (pick < 62)
        begin
            c.mode = MODE_COLLIDE;
        end
        else if (pick < 85)
        begin
            c.mode = MODE_MOVE;
        end
        else
        begin
            c.mode = MODE_PLACE;
        end
        // mostly moderate vectors, now and then the full range
        if ($urandom_range(0, 99) < 8)
        begin
            c.vec_x = $urandom();
            c.vec_y = $urandom();
        end
        else if (c.mode == MODE_PLACE)
        begin
            c.vec_x = spread(25);
            c.vec_y = spread(25);
        end
        else
        begin
            c.vec_x = spread(19);
            c.vec_y = spread(19);
        end
        c.normal_x = random_normal_part();
        c.normal_y = random_normal_part();
        c.dir = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
        return c;
    endfunction

    function automatic regset_t phase_regs(input int phase);
        regset_t r;
        r.drag     = 16'($urandom_range(28000, 32768));
        r.gravity  = spread(18);
        r.friction = 16'($urandom_range(0, 8192));
        r.bounce   = 16'($urandom_range(0, 32768));
        r.push     = 31'($urandom_range(0, 1 << 18));
        r.limit    = 31'($urandom_range(0, 1 << 20));
        case (phase)
            1:
            begin
                r = '{16'd0, 32'h8000_0000, 16'd0, 16'd0, 31'd0, 31'd0};
            end
            2:
            begin
                r = '{16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF,
                      31'h7FFF_FFFF, 31'h7FFF_FFFF};
            end
            3:
            begin
                r.drag     = 16'd32768;
                r.gravity  = -32'sd13107;
                r.friction = 16'd32768;
                r.bounce   = 16'd32768;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  %s", $time, msg);
        mismatch_count++;
    endtask

    // write all six registers back to back, block idle
    task automatic program_regs(input regset_t r);
        logic [2:0] order [0:5];
        int i;
        order = '{REG_DRAG, REG_GRAVITY, REG_FRICTION, REG_BOUNCE, REG_PUSH, REG_LIMIT};
        for (i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            case (order[i])
                REG_DRAG:     cfg_data <= {16'd0, r.drag};
                REG_GRAVITY:  cfg_data <= r.gravity;
                REG_FRICTION: cfg_data <= {16'd0, r.friction};
                REG_BOUNCE:   cfg_data <= {16'd0, r.bounce};
                REG_PUSH:     cfg_data <= {1'b0, r.push};
                default:      cfg_data <= {1'b0, r.limit};
            endcase
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
        end
        cfg_valid  <= 1'b0;
        k_drag     = r.drag;
        g_accel    = r.gravity;
        k_friction = r.friction;
        k_bounce   = r.bounce;
        v_push     = r.push;
        v_max      = r.limit;
    endtask

    // send one request and queue the position it should produce
    task automatic send_request(input step_cmd_t c, input logic typed, input point_t want);
        point_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.mode;
        s_tdata  <= {5'd0, c.dir, c.normal_y, c.normal_x, c.vec_y, c.vec_x};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = advance_point(c);
        expected_pos.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        while (expected_pos.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver stalls and output check
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pos.size() == 0)
            begin
                report_mismatch($sformatf("position %h with nothing pending", m_tdata));
            end
            else
            begin
                out_want = expected_pos.pop_front();
                if (m_tdata[31:0] !== out_want.x)
                begin
                    report_mismatch($sformatf("pos_x got %h expected %h",
                                              m_tdata[31:0], out_want.x));
                end
                if (m_tdata[63:32] !== out_want.y)
                begin
                    report_mismatch($sformatf("pos_y got %h expected %h",
                                              m_tdata[63:32], out_want.y));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        sim_cycles <= sim_cycles + 1;
        if (sim_cycles > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        rst_n             <= 1'b0;
        s_tvalid          <= 1'b0;
        s_tdata           <= '0;
        s_tuser           <= MODE_INTEGRATE;
        m_tready          <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= REG_DRAG;
        cfg_data          <= '0;
        mismatch_count    = 0;
        sim_cycles        = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        here_x = '0;
        here_y = '0;
        last_x = '0;
        last_y = '0;
        k_drag     = DRAG_RESET;
        g_accel    = GRAVITY_RESET;
        k_friction = FRICTION_RESET;
        k_bounce   = BOUNCE_RESET;
        v_push     = '0;
        v_max      = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests on reset register values
        for (n = 0; n < $size(directed_rows); n++)
        begin
            send_request(directed_rows[n].cmd, directed_rows[n].typed,
                         directed_rows[n].pos);
        end
        s_tvalid <= 1'b0;

        // random requests, new registers and idle pattern per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            program_regs(phase_regs(phase));
            case (phase % 4)
                0:       begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
                1:       begin sender_idle_pct = 53; receiver_idle_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_idle_pct = 53; end
                default: begin sender_idle_pct = 14; receiver_idle_pct = 14; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_request(random_cmd(), 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/vpcs_pkg.sv
hdl/verlet_point_collision_step_unit.sv
sim/verlet_point_collision_step_unit_test.sv
